// ===== design/wsfu_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfu_pkg
// shared types and codes for the websocket frame unmasker
// ----------------------------------------------------------------------------
package wsfu_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_RSV_SET  = 2'd1;
    localparam logic [1:0] STAT_UNMASKED = 2'd2;
    localparam logic [1:0] STAT_BAD_OP   = 2'd3;

    // length escape codes of the 7-bit length field
    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;

    // one classified item handed from the parser to the output side
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pay_byte;
        logic [7:0]  key_byte;
        logic [3:0]  opcode;
        logic        fin;
        logic [63:0] length;
        logic [1:0]  status;
        logic        last;
    } wsfu_item_t;

    function automatic logic opcode_known(input logic [3:0] op);
        logic known;
        case (op)
            4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd10: known = 1'b1;
            default:                             known = 1'b0;
        endcase
        return known;
    endfunction

endpackage

// ===== design/wsfu_front.sv =====
// ----------------------------------------------------------------------------
// wsfu_front
// header parser: walks the frame bytes and classifies each one
// ----------------------------------------------------------------------------
module wsfu_front
    import wsfu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output logic       push,
    output wsfu_item_t item
);

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;

    logic [2:0]  phase_reg,  phase_next;
    logic [3:0]  count_reg,  count_next;
    logic [63:0] remain_reg, remain_next;
    logic [31:0] key_reg,    key_next;
    logic [1:0]  kpos_reg,   kpos_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        fin_reg,    fin_next;

    logic [3:0]  count_dec;
    logic [63:0] remain_dec;
    logic [31:0] key_shift;
    logic [7:0]  key_sel;

    assign count_dec  = count_reg - 4'd1;
    assign remain_dec = remain_reg - 64'd1;
    assign key_shift  = {key_reg[23:0], in_byte};

    always_comb
    begin
        case (kpos_reg)
            2'd0:    key_sel = key_reg[31:24];
            2'd1:    key_sel = key_reg[23:16];
            2'd2:    key_sel = key_reg[15:8];
            default: key_sel = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        key_next    = key_reg;
        kpos_next   = kpos_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        push        = 1'b0;
        item        = '{kind: KIND_HEADER, pay_byte: 8'd0, key_byte: 8'd0,
                        opcode: opcode_reg, fin: fin_reg, length: 64'd0,
                        status: STAT_OK, last: 1'b0};
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    phase_next = PH_HDR0;
                    if (!in_byte[7])
                    begin
                        push        = 1'b1;
                        item.kind   = KIND_ERROR;
                        item.status = STAT_UNMASKED;
                    end
                    else if (!opcode_known(opcode_reg))
                    begin
                        push        = 1'b1;
                        item.kind   = KIND_ERROR;
                        item.status = STAT_BAD_OP;
                    end
                    else if (in_byte[6:0] == LEN16_CODE)
                    begin
                        remain_next = 64'd0;
                        count_next  = 4'd2;
                        phase_next  = PH_EXT;
                    end
                    else if (in_byte[6:0] == LEN64_CODE)
                    begin
                        remain_next = 64'd0;
                        count_next  = 4'd8;
                        phase_next  = PH_EXT;
                    end
                    else
                    begin
                        remain_next = {57'd0, in_byte[6:0]};
                        count_next  = 4'd4;
                        phase_next  = PH_KEY;
                    end
                end
                PH_EXT:
                begin
                    remain_next = {remain_reg[55:0], in_byte};
                    count_next  = count_dec;
                    if (count_dec == 4'd0)
                    begin
                        count_next = 4'd4;
                        phase_next = PH_KEY;
                    end
                end
                PH_KEY:
                begin
                    key_next   = key_shift;
                    count_next = count_dec;
                    if (count_dec == 4'd0)
                    begin
                        kpos_next = 2'd0;
                        push      = 1'b1;
                        if (remain_reg == 64'd0)
                        begin
                            phase_next = PH_HDR0;
                            item.last  = 1'b1;
                        end
                        else
                        begin
                            phase_next  = PH_PAY;
                            item.length = remain_reg;
                        end
                    end
                end
                PH_PAY:
                begin
                    kpos_next     = kpos_reg + 2'd1;
                    remain_next   = remain_dec;
                    push          = 1'b1;
                    item.kind     = KIND_PAYLOAD;
                    item.pay_byte = in_byte;
                    item.key_byte = key_sel;
                    item.last     = (remain_dec == 64'd0);
                    if (remain_dec == 64'd0)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    // first header byte; unused phase codes land here too
                    fin_next    = in_byte[7];
                    opcode_next = in_byte[3:0];
                    item.fin    = in_byte[7];
                    item.opcode = in_byte[3:0];
                    if (in_byte[6:4] != 3'd0)
                    begin
                        phase_next  = PH_HDR0;
                        push        = 1'b1;
                        item.kind   = KIND_ERROR;
                        item.status = STAT_RSV_SET;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            count_reg  <= 4'd0;
            remain_reg <= 64'd0;
            key_reg    <= 32'd0;
            kpos_reg   <= 2'd0;
            opcode_reg <= 4'd0;
            fin_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            key_reg    <= key_next;
            kpos_reg   <= kpos_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
        end
    end

endmodule

// ===== design/wsfu_queue.sv =====
// ----------------------------------------------------------------------------
// wsfu_queue
// short first-in first-out queue of classified items
// ----------------------------------------------------------------------------
module wsfu_queue
    import wsfu_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  wsfu_item_t push_item,
    input  logic       pop,
    output logic       not_empty,
    output logic       full,
    output wsfu_item_t head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    wsfu_item_t slot_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg,    cnt_next;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== design/wsfu_back.sv =====
// ----------------------------------------------------------------------------
// wsfu_back
// output stage: unmasks payload bytes and holds the result for the consumer
// ----------------------------------------------------------------------------
module wsfu_back
    import wsfu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_avail,
    input  wsfu_item_t head,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data,
    output logic [3:0]  frame_opcode,
    output logic        fin,
    output logic [63:0] payload_length,
    output logic [1:0]  status,
    output logic        last
);

    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  data_reg;
    logic [3:0]  opcode_reg;
    logic        fin_reg;
    logic [63:0] length_reg;
    logic [1:0]  status_reg;
    logic        last_reg;

    assign pop = item_avail && (!valid_reg || result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // key byte is zero on non-payload items, so data comes out zero there
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg   <= head.kind;
            data_reg   <= head.pay_byte ^ head.key_byte;
            opcode_reg <= head.opcode;
            fin_reg    <= head.fin;
            length_reg <= head.length;
            status_reg <= head.status;
            last_reg   <= head.last;
        end
    end

    assign result_valid   = valid_reg;
    assign kind           = kind_reg;
    assign data           = data_reg;
    assign frame_opcode   = opcode_reg;
    assign fin            = fin_reg;
    assign payload_length = length_reg;
    assign status         = status_reg;
    assign last           = last_reg;

endmodule

// ===== design/websocket_frame_unmasker.sv =====
// a result passes from the parser through the item queue into the output register
// throughput: one byte per cycle while the queue has room, set by the parser step
//   and the length decrement in the payload phase
// a stalled consumer is absorbed by the item queue plus the output register
// reset (rst_n low, asynchronous): parser expects a new frame, queue and output
//   register empty; no clearing pass is needed
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// byte-serial client-to-server frame parser with payload unmasking
// ----------------------------------------------------------------------------
module websocket_frame_unmasker
    import wsfu_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // incoming frame bytes
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  in_byte,
    // results
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data,
    output logic [3:0]  frame_opcode,
    output logic        fin,
    output logic [63:0] payload_length,
    output logic [1:0]  status,
    output logic        last
);

    logic       accept;
    logic       push;
    wsfu_item_t push_item;
    logic       pop;
    logic       not_empty;
    logic       full;
    wsfu_item_t head;

    // a byte is taken whenever the queue has room, even if it yields no result
    assign byte_ready = !full;
    assign accept     = byte_valid && byte_ready;

    // front: header state machine, key capture, length countdown
    wsfu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .push    (push),
        .item    (push_item)
    );

    // decouples the parser from a stalling consumer
    wsfu_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .not_empty (not_empty),
        .full      (full),
        .head      (head)
    );

    // back: xor with the key byte and register the result
    wsfu_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_avail     (not_empty),
        .head           (head),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .kind           (kind),
        .data           (data),
        .frame_opcode   (frame_opcode),
        .fin            (fin),
        .payload_length (payload_length),
        .status         (status),
        .last           (last)
    );

endmodule

// ===== design/wsfu_checker.sv =====
// ----------------------------------------------------------------------------
// wsfu_checker
// port-level checks on the frame unmasker results
// ----------------------------------------------------------------------------
module wsfu_checker
    import wsfu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_ready,
    input logic [7:0]  in_byte,
    input logic        result_valid,
    input logic        result_ready,
    input logic [1:0]  kind,
    input logic [7:0]  data,
    input logic [3:0]  frame_opcode,
    input logic        fin,
    input logic [63:0] payload_length,
    input logic [1:0]  status,
    input logic        last
);

    // a waiting input byte holds
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> byte_valid && $stable(in_byte))
    else $error("waiting input byte changed");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(kind) && $stable(data) && $stable(last)
            && $stable(payload_length) && $stable(status)
            && $stable(frame_opcode) && $stable(fin))
    else $error("stalled result changed");

    // header: last flags exactly the empty frame
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_HEADER |->
            status == STAT_OK && data == 8'd0
            && last == (payload_length == 64'd0))
    else $error("bad header result");

    // payload bytes carry no length and no status
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_PAYLOAD |->
            status == STAT_OK && payload_length == 64'd0)
    else $error("bad payload result");

    // errors carry a nonzero status, no data, no length and no last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_ERROR |->
            status != STAT_OK && data == 8'd0 && last == 1'b0
            && payload_length == 64'd0)
    else $error("bad error result");

endmodule

bind websocket_frame_unmasker wsfu_checker u_wsfu_checker (.*);

// ===== verif/websocket_frame_unmasker_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_unmasker_checker
// tracks frame parsing from the accepted bytes and compares every result
// ----------------------------------------------------------------------------
module websocket_frame_unmasker_checker
    import wsfu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_ready,
    input  logic [7:0]  in_byte,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  data,
    input  logic [3:0]  frame_opcode,
    input  logic        fin,
    input  logic [63:0] payload_length,
    input  logic [1:0]  status,
    input  logic        last,
    output int          mismatches,
    output int          outstanding,
    output int          results_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [2:0] {
        AWAIT_FIRST,
        AWAIT_LEN,
        EXT_LEN,
        KEY_BYTES,
        PAYLOAD
    } parse_phase_t;

    typedef enum logic [3:0] {
        OPC_CONT   = 4'd0,
        OPC_TEXT   = 4'd1,
        OPC_BINARY = 4'd2,
        OPC_CLOSE  = 4'd8,
        OPC_PING   = 4'd9,
        OPC_PONG   = 4'd10
    } frame_opcode_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [3:0]  opcode;
        logic        fin;
        logic [63:0] length;
        logic [1:0]  status;
        logic        last;
    } frame_result_t;

    parse_phase_t  phase_q;
    logic [3:0]    hdr_left;
    logic [63:0]   len_left;
    logic [31:0]   key_word;
    logic [1:0]    key_idx;
    logic [3:0]    cur_op;
    logic          cur_fin;
    frame_result_t unmask_results_q[$];

    function automatic logic is_defined_opcode(input logic [3:0] op);
        case (op)
            OPC_CONT, OPC_TEXT, OPC_BINARY, OPC_CLOSE, OPC_PING, OPC_PONG: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic frame_result_t make_result(input logic [1:0] k, input logic [7:0] d,
                                                  input logic [63:0] len, input logic [1:0] st,
                                                  input logic lst);
        frame_result_t r;
        r.kind   = k;
        r.data   = d;
        r.opcode = cur_op;
        r.fin    = cur_fin;
        r.length = len;
        r.status = st;
        r.last   = lst;
        return r;
    endfunction

    // append one expected result at the tail
    task automatic expect_result(input frame_result_t r);
        unmask_results_q = {unmask_results_q, r};
    endtask

    // advance the frame parser by one byte, queue whatever result it yields
    task automatic frame_parse_step(input logic [7:0] b);
        logic [7:0] kb;
        case (phase_q)
            AWAIT_LEN:
            begin
                phase_q = AWAIT_FIRST;
                if (!b[7])
                    expect_result(make_result(KIND_ERROR, '0, '0, STAT_UNMASKED, 1'b0));
                else if (!is_defined_opcode(cur_op))
                    expect_result(make_result(KIND_ERROR, '0, '0, STAT_BAD_OP, 1'b0));
                else
                begin
                    len_left = '0;
                    if (b[6:0] == LEN16_CODE)
                    begin
                        hdr_left = 4'd2;
                        phase_q  = EXT_LEN;
                    end
                    else if (b[6:0] == LEN64_CODE)
                    begin
                        hdr_left = 4'd8;
                        phase_q  = EXT_LEN;
                    end
                    else
                    begin
                        len_left = {57'd0, b[6:0]};
                        hdr_left = 4'd4;
                        phase_q  = KEY_BYTES;
                    end
                end
            end
            EXT_LEN:
            begin
                len_left = {len_left[55:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                begin
                    hdr_left = 4'd4;
                    phase_q  = KEY_BYTES;
                end
            end
            KEY_BYTES:
            begin
                key_word = {key_word[23:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                begin
                    key_idx = '0;
                    if (len_left == '0)
                    begin
                        phase_q = AWAIT_FIRST;
                        expect_result(make_result(KIND_HEADER, '0, '0, STAT_OK, 1'b1));
                    end
                    else
                    begin
                        phase_q = PAYLOAD;
                        expect_result(make_result(KIND_HEADER, '0, len_left, STAT_OK, 1'b0));
                    end
                end
            end
            PAYLOAD:
            begin
                // first key byte received masks payload byte 0
                kb       = key_word[8 * (3 - int'(key_idx)) +: 8];
                key_idx  = key_idx + 2'd1;
                len_left = len_left - 64'd1;
                expect_result(
                    make_result(KIND_PAYLOAD, b ^ kb, '0, STAT_OK, len_left == '0));
                if (len_left == '0)
                    phase_q = AWAIT_FIRST;
            end
            default:
            begin
                cur_fin = b[7];
                cur_op  = b[3:0];
                if (b[6:4] != 3'd0)
                    expect_result(make_result(KIND_ERROR, '0, '0, STAT_RSV_SET, 1'b0));
                else
                    phase_q = AWAIT_LEN;
            end
        endcase
    endtask

    task automatic check_result();
        frame_result_t got;
        frame_result_t want;
        string         bad;
        got = '{kind, data, frame_opcode, fin, payload_length, status, last};
        results_checked++;
        if (unmask_results_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: unexpected result kind=%0d data=%02h op=%0d fin=%0b %s",
                         $realtime, got.kind, got.data, got.opcode, got.fin,
                         $sformatf("len=%0d st=%0d last=%0b", got.length, got.status,
                                   got.last));
            return;
        end
        want = unmask_results_q.pop_front();
        bad  = "";
        if (got.kind !== want.kind)     bad = {bad, " kind"};
        if (got.data !== want.data)     bad = {bad, " data"};
        if (got.opcode !== want.opcode) bad = {bad, " frame_opcode"};
        if (got.fin !== want.fin)       bad = {bad, " fin"};
        if (got.length !== want.length) bad = {bad, " payload_length"};
        if (got.status !== want.status) bad = {bad, " status"};
        if (got.last !== want.last)     bad = {bad, " last"};
        if (bad != "")
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("%0t: result mismatch on%s", $realtime, bad);
                $display("  expected kind=%0d data=%02h op=%0d fin=%0b len=%0d st=%0d last=%0b",
                         want.kind, want.data, want.opcode, want.fin, want.length,
                         want.status, want.last);
                $display("  actual   kind=%0d data=%02h op=%0d fin=%0b len=%0d st=%0d last=%0b",
                         got.kind, got.data, got.opcode, got.fin, got.length,
                         got.status, got.last);
            end
        end
    endtask

    // sampled on the falling edge: values then are the ones seen by the next rising edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            phase_q  = AWAIT_FIRST;
            hdr_left = '0;
            len_left = '0;
            key_word = '0;
            key_idx  = '0;
            cur_op   = '0;
            cur_fin  = 1'b0;
            unmask_results_q.delete();
        end
        else
        begin
            if (result_valid && result_ready)
                check_result();
            if (byte_valid && byte_ready)
                frame_parse_step(in_byte);
        end
        outstanding = unmask_results_q.size();
    end

endmodule

// ===== verif/websocket_frame_unmasker_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_unmasker_tb
// streams client frames through the unmasker: a short directed set of edge
// frames, then random well-formed frames mixed with broken headers, with
// random stalls on both sides; a checker module compares every result
// ----------------------------------------------------------------------------
module websocket_frame_unmasker_tb
    import wsfu_pkg::*;
;

    localparam int TOTAL_BYTES  = 1550;   // stimulus stops once this many bytes went in
    localparam int STALL_LIMIT  = 2000;   // cycles with no handshake before giving up
    localparam int IDLE_PERCENT = 23;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic [7:0]  in_byte      = '0;
    logic        result_ready = 1'b0;
    logic        byte_ready;
    logic        result_valid;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [3:0]  frame_opcode;
    logic        fin;
    logic [63:0] payload_length;
    logic [1:0]  status;
    logic        last;

    int mismatches;
    int outstanding;
    int results_checked;

    // run statistics for the closing summary
    int  bytes_sent   = 0;
    int  frames_sent  = 0;
    int  bad_headers  = 0;
    int  stall_cycles = 0;
    // high during the stretch where neither side inserts idle cycles
    logic steady = 1'b0;

    websocket_frame_unmasker u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .in_byte        (in_byte),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .kind           (kind),
        .data           (data),
        .frame_opcode   (frame_opcode),
        .fin            (fin),
        .payload_length (payload_length),
        .status         (status),
        .last           (last)
    );

    websocket_frame_unmasker_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_ready      (byte_ready),
        .in_byte         (in_byte),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .kind            (kind),
        .data            (data),
        .frame_opcode    (frame_opcode),
        .fin             (fin),
        .payload_length  (payload_length),
        .status          (status),
        .last            (last),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: random back-pressure, none during the steady stretch
    always @(posedge clk)
        result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // watchdog: any handshake restarts the count
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && byte_ready) || (result_valid && result_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, outstanding);
                $display("websocket_frame_unmasker_tb: FAIL");
                $finish;
            end
        end
    end

    // pick an opcode the parser accepts (want_known) or one it rejects
    function automatic logic [3:0] pick_opcode(input logic want_known);
        logic [3:0] op;
        do
            op = 4'($urandom_range(0, 15));
        while (opcode_known(op) != want_known);
        return op;
    endfunction

    // one byte on the input channel; random idle cycles ahead of it
    task automatic push_byte(input logic [7:0] b);
        logic took;
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        in_byte    <= b;
        do
        begin
            @(negedge clk);
            took = byte_ready;
            @(posedge clk);
        end
        while (!took);
        bytes_sent++;
    endtask

    // builds a frame from its header fields; stops where the header is
    // rejected, otherwise follows with extended length, key and payload
    task automatic send_frame(input logic fin_bit, input logic [2:0] rsv, input logic [3:0] op,
                              input logic masked, input logic [6:0] len_code,
                              input logic [63:0] ext_len, input logic [31:0] key);
        logic [63:0] n;
        logic [7:0]  pb;
        push_byte({fin_bit, rsv, op});
        if (rsv != 3'd0)
        begin
            bad_headers++;
            return;
        end
        push_byte({masked, len_code});
        if (!masked || !opcode_known(op))
        begin
            bad_headers++;
            return;
        end
        if (len_code == LEN16_CODE)
        begin
            n = {48'd0, ext_len[15:0]};
            for (int i = 1; i >= 0; i--)
                push_byte(ext_len[8 * i +: 8]);
        end
        else if (len_code == LEN64_CODE)
        begin
            n = ext_len;
            for (int i = 7; i >= 0; i--)
                push_byte(ext_len[8 * i +: 8]);
        end
        else
            n = {57'd0, len_code};
        for (int i = 3; i >= 0; i--)
            push_byte(key[8 * i +: 8]);
        // payload leans on the byte extremes now and then
        for (longint i = 0; i < longint'(n); i++)
        begin
            case ($urandom_range(0, 9))
                0:       pb = 8'h00;
                1:       pb = 8'hFF;
                default: pb = 8'($urandom);
            endcase
            push_byte(pb);
        end
        frames_sent++;
    endtask

    initial
    begin
        logic        drained_once;
        int          roll;
        int          mode;
        logic [6:0]  len_code;
        logic [63:0] ext_len;
        drained_once = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every reserved bit set with all-ones opcode, then straight
        // into an all-zero unmasked header to show the parser resynced
        send_frame(1'b1, 3'b111, '1, 1'b1, LEN64_CODE, '0, '0);
        send_frame(1'b0, 3'b000, '0, 1'b0, 7'd0, '0, '0);
        // unmasked frame with an unknown opcode: the mask check wins
        send_frame(1'b1, 3'b000, pick_opcode(1'b0), 1'b0, LEN64_CODE, '0, '0);
        // masked frame with an unknown opcode
        send_frame(1'b0, 3'b000, pick_opcode(1'b0), 1'b1, 7'd0, '0, '0);
        // non-minimal 16-bit length carrying two payload bytes
        send_frame(1'b1, 3'b000, pick_opcode(1'b1), 1'b1, LEN16_CODE, 64'd2, 32'hFF00_A55A);
        // 64-bit length of zero: header marks the empty frame as last
        send_frame(1'b0, 3'b000, pick_opcode(1'b1), 1'b1, LEN64_CODE, '0, '1);

        // random: mostly well-formed frames, the rest rejected headers
        while (bytes_sent < TOTAL_BYTES)
        begin
            steady <= (bytes_sent >= 500) && (bytes_sent < 800);
            if (!drained_once && bytes_sent >= 1000)
            begin
                // sender holds off until every result has come out
                drained_once = 1'b1;
                byte_valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 72)
            begin
                mode    = $urandom_range(0, 9);
                ext_len = '0;
                if (mode < 7)
                begin
                    if ($urandom_range(0, 5) == 0)
                        len_code = 7'($urandom_range(13, int'(LEN16_CODE) - 1));
                    else
                        len_code = 7'($urandom_range(0, 12));
                end
                else if (mode < 9)
                begin
                    len_code = LEN16_CODE;
                    ext_len  = 64'($urandom_range(0, 180));
                end
                else
                begin
                    len_code = LEN64_CODE;
                    ext_len  = 64'($urandom_range(0, 30));
                end
                send_frame(1'($urandom), 3'b000, pick_opcode(1'b1), 1'b1, len_code, ext_len,
                           $urandom);
            end
            else if (roll < 82)
                send_frame(1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom), 1'b1,
                           7'($urandom), '0, '0);
            else if (roll < 91)
                send_frame(1'($urandom), 3'b000, 4'($urandom), 1'b0, 7'($urandom), '0, '0);
            else
                send_frame(1'($urandom), 3'b000, pick_opcode(1'b0), 1'b1, 7'($urandom), '0, '0);
        end

        byte_valid <= 1'b0;
        steady     <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        // keep the clock running to catch any stray result
        repeat (8) @(posedge clk);

        $display("coverage: %0d bytes in, %0d complete frames, %0d rejected headers",
                 bytes_sent, frames_sent, bad_headers);
        $display("coverage: %0d results compared, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("websocket_frame_unmasker_tb: PASS");
        else
            $display("websocket_frame_unmasker_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/wsfu_pkg.sv
design/wsfu_front.sv
design/wsfu_queue.sv
design/wsfu_back.sv
design/websocket_frame_unmasker.sv
design/wsfu_checker.sv
verif/websocket_frame_unmasker_checker.sv
verif/websocket_frame_unmasker_tb.sv
